// File: rtl/core/mdaa_pkg.sv
// Shared package for the multidimensional array address block.
// Holds field widths, op codes, sequencer states and the descriptor entry layouts.
// No dependencies.
package mdaa_pkg;

  localparam int DATA_W      = 32;
  localparam int ID_W        = 4;
  localparam int DIM_W       = 4;
  localparam int OP_W        = 2;
  localparam int NUM_ARRAYS_DEF = 16;
  localparam int MAX_DIMS_DEF   = 10;

  typedef enum logic [OP_W-1:0] {
    OP_HEADER = 2'd0,
    OP_BOUNDS = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_SCALE,
    S_ADD
  } state_t;

  // Array header: dimension count, element size, base address
  typedef struct packed {
    logic [DIM_W-1:0]  dims;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] base;
  } hdr_t;

  // Per-dimension entry: lower bound and extent
  typedef struct packed {
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] extent;
  } dent_t;

endpackage

// File: rtl/core/mdaa_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while the read enable is low.
// No dependencies.
module mdaa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/multidim_array_address_top.sv
// Row-major address calculator for multidimensional arrays: top level.
// Depends on mdaa_pkg and mdaa_ram (header store and per-dimension bounds store).
//
// Keeps NUM_ARRAYS array descriptors (base, element size, dimension count) and
// NUM_ARRAYS*MAX_DIMS dimension entries (lower bound, extent) in two synchronous
// RAMs. Header (op 0) and bounds (op 1) beats, and ignored beats, leave the
// sequencer idle. A query index (op 2) reads both RAMs, then does one multiply
// and one add into the running offset. The index for the last dimension adds a
// second multiply by the element size and the base add, and waits while the
// result register is still stalled. A single shared 32x32 multiplier serves
// both multiplies and its product is registered. Indices are sent in dimension
// order 1..D; arithmetic wraps modulo 2^32. A finished address waits in the
// output register while the next beat is taken.
module multidim_array_address_top #(
  parameter int NUM_ARRAYS = mdaa_pkg::NUM_ARRAYS_DEF,
  parameter int MAX_DIMS   = mdaa_pkg::MAX_DIMS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic        [mdaa_pkg::OP_W-1:0]         in_op,
  input  logic        [mdaa_pkg::ID_W-1:0]         in_array_id,
  input  logic        [mdaa_pkg::DIM_W-1:0]        in_dim,
  input  logic signed [mdaa_pkg::DATA_W-1:0]       in_first_value,
  input  logic signed [mdaa_pkg::DATA_W-1:0]       in_second_value,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [mdaa_pkg::DATA_W-1:0]       out_address,
  output logic        [mdaa_pkg::ID_W-1:0]         out_array_ref
);

  import mdaa_pkg::*;

  localparam int ARR_W      = NUM_ARRAYS > 1 ? $clog2(NUM_ARRAYS) : 1;
  localparam int SLOT_DEPTH = NUM_ARRAYS * MAX_DIMS;
  localparam int SLOT_W     = SLOT_DEPTH > 1 ? $clog2(SLOT_DEPTH) : 1;

  state_t state_r, state_nxt;

  // item latched at accept
  logic [ID_W-1:0]   q_id_r;
  logic [DIM_W-1:0]  q_dim_r;
  logic [DATA_W-1:0] q_idx_r;

  logic [DATA_W-1:0] running_offset_r, running_offset_nxt;
  logic [DATA_W-1:0] prod_r, prod_nxt;
  logic [DATA_W-1:0] diff_r, diff_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_address_r;
  logic [ID_W-1:0]   out_array_ref_r;
  logic              out_load;

  logic              accept;
  logic              id_ok, dim_ok;
  logic [ARR_W-1:0]  hdr_addr;
  logic [SLOT_W-1:0] slot;
  logic [DATA_W-1:0] v1, v2;

  logic              hdr_we, dent_we, rd_en;
  hdr_t              hdr_wdata, hdr_rdata;
  dent_t             dent_wdata, dent_rdata;

  logic [DATA_W-1:0]   mul_a, mul_b;
  logic [DATA_W-1:0]   mul_lo;
  logic [DATA_W-1:0]   prev;

  assign v1       = in_first_value;
  assign v2       = in_second_value;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  assign id_ok    = 32'(in_array_id) < 32'(NUM_ARRAYS);
  assign dim_ok   = (in_dim != '0) && (32'(in_dim) <= 32'(MAX_DIMS));
  assign hdr_addr = ARR_W'(in_array_id);
  assign slot     = SLOT_W'(32'(hdr_addr) * 32'(MAX_DIMS) + 32'(in_dim) - 32'd1);

  assign hdr_we  = accept && id_ok && (in_op == OP_HEADER);
  assign dent_we = accept && id_ok && dim_ok && (in_op == OP_BOUNDS);
  assign rd_en   = accept && id_ok && dim_ok && (in_op == OP_QUERY);

  always_comb begin
    hdr_wdata.base = v1;
    hdr_wdata.size = v2;
    hdr_wdata.dims = (32'(in_dim) > 32'(MAX_DIMS)) ? DIM_W'(MAX_DIMS) : in_dim;
    dent_wdata.lower  = v1;
    dent_wdata.extent = v2 - v1 + 32'd1;
  end

  mdaa_ram #(
    .WIDTH ($bits(hdr_t)),
    .DEPTH (NUM_ARRAYS)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (hdr_addr),
    .wdata (hdr_wdata),
    .re    (rd_en),
    .raddr (hdr_addr),
    .rdata (hdr_rdata)
  );

  mdaa_ram #(
    .WIDTH ($bits(dent_t)),
    .DEPTH (SLOT_DEPTH)
  ) u_dent_ram (
    .clk   (clk),
    .we    (dent_we),
    .waddr (slot),
    .wdata (dent_wdata),
    .re    (rd_en),
    .raddr (slot),
    .rdata (dent_rdata)
  );

  // dimension 1 restarts the Horner sum
  assign prev = (q_dim_r == DIM_W'(1)) ? '0 : running_offset_r;

  // one shared multiplier: Horner step in S_MUL, element size in S_SCALE
  always_comb begin
    mul_a = prev;
    mul_b = dent_rdata.extent;
    if (state_r == S_SCALE) begin
      mul_a = running_offset_r;
      mul_b = hdr_rdata.size;
    end
  end
  // only the low word is kept, so the product wraps modulo 2^32
  assign mul_lo = mul_a * mul_b;

  assign out_load = (state_r == S_ADD) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt          = state_r;
    running_offset_nxt = running_offset_r;
    prod_nxt           = prod_r;
    diff_nxt           = diff_r;
    out_valid_nxt      = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (hdr_we) begin
          running_offset_nxt = '0;
        end
        if (rd_en) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (hdr_rdata.dims == '0) begin
          // no dimensions: the base address goes out as it is
          running_offset_nxt = '0;
          prod_nxt           = '0;
          state_nxt          = S_ADD;
        end else begin
          prod_nxt  = mul_lo;
          diff_nxt  = q_idx_r - dent_rdata.lower;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        running_offset_nxt = prod_r + diff_r;
        state_nxt = (q_dim_r == hdr_rdata.dims) ? S_SCALE : S_IDLE;
      end
      S_SCALE: begin
        prod_nxt  = mul_lo;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (out_load) begin
          running_offset_nxt = '0;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      running_offset_r <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      running_offset_r <= running_offset_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    diff_r <= diff_nxt;
    if (accept) begin
      q_id_r  <= in_array_id;
      q_dim_r <= in_dim;
      q_idx_r <= v1;
    end
    if (out_load) begin
      out_address_r   <= hdr_rdata.base + prod_r;
      out_array_ref_r <= q_id_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_address   = out_address_r;
  assign out_array_ref = out_array_ref_r;

endmodule
